[rtl/vna_pkg.sv]
// ---------------------------------------------------------------------------
// Vertex normal averager package
// Shared widths, codes, controller/datapath interface types and helpers.
// ---------------------------------------------------------------------------
package vna_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int AW           = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  localparam int IDX_W      = 6;
  localparam int TOT_W      = 7;
  localparam int POS_W      = 16;
  localparam int DIF_W      = 17;
  localparam int NRM_W      = 36;
  localparam int HALF_W     = NRM_W / 2;
  localparam int ACC_W      = 48;
  localparam int TCNT_W     = 16;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int SUM_W      = 72;
  localparam int ROOT_W     = 36;
  localparam int FM_W       = 30;
  localparam int QN_W       = 15;
  localparam int FRAC_W     = 14;
  localparam int REM_W      = 46;
  localparam int OUT_N_W    = 16;
  localparam int POS_WORD_W = 3 * POS_W;
  localparam int ACC_WORD_W = 3 * ACC_W + TCNT_W;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 96;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_FIN  = 2'd2
  } cmd_e;

  typedef enum logic {
    KIND_TRI  = 1'b0,
    KIND_VERT = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    MUL_YZ, MUL_ZY, MUL_ZX, MUL_XZ, MUL_XY, MUL_YX,
    MUL_SQ_HH, MUL_SQ_HL, MUL_SQ_LL, MUL_FIN
  } mul_sel_e;

  typedef enum logic [3:0] {
    P_NONE, P_NX_LD, P_NX_SUB, P_NY_LD, P_NY_SUB, P_NZ_LD, P_NZ_SUB,
    P_ADD_HH, P_ADD_HL, P_ADD_LL
  } p_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_RD_A, ST_RD_B, ST_RD_C, ST_LAT_C, ST_CROSS, ST_SQ,
    ST_DRAIN, ST_SQRT_GO, ST_SQRT_WAIT, ST_ACC_RD, ST_ACC_WR, ST_EMIT_T,
    ST_F_RD, ST_F_LAT, ST_F_CHK, ST_F_SHIFT, ST_F_SQ, ST_F_DIV_INIT,
    ST_F_DIV_STEP, ST_F_DIV_ST, ST_F_EMIT, ST_F_CLR
  } state_e;

  typedef struct packed {
    logic     cap_in;
    logic     pos_we;
    logic     pos_re;
    logic [1:0] comp;
    logic     lat_pa;
    logic     lat_d1;
    logic     lat_d2;
    mul_sel_e mul_sel;
    p_op_e    p_op;
    logic     sum_clr;
    logic     sqrt_start;
    logic     len_lat;
    logic     acc_re;
    logic     acc_vert;
    logic     acc_we;
    logic     f_lat;
    logic     f_shift;
    logic     div_init;
    logic     div_step;
    logic     div_store;
    logic     out_load;
    kind_e    out_kind;
    logic     vc_clr;
    logic     vc_inc;
    logic     valid_clr;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic cmd_known;
    logic tri_ok;
    logic total_zero;
    logic vc_last;
    logic out_free;
    logic need_shift;
    logic norm_zero;
    logic sqrt_done;
  } dp_stat_t;

  // Cross product schedule: the product issued at step k and how it is folded in.
  function automatic mul_sel_e cross_mul(input logic [3:0] k);
    case (k)
      4'd0:    cross_mul = MUL_YZ;
      4'd1:    cross_mul = MUL_ZY;
      4'd2:    cross_mul = MUL_ZX;
      4'd3:    cross_mul = MUL_XZ;
      4'd4:    cross_mul = MUL_XY;
      default: cross_mul = MUL_YX;
    endcase
  endfunction

  function automatic p_op_e cross_op(input logic [3:0] k);
    case (k)
      4'd0:    cross_op = P_NX_LD;
      4'd1:    cross_op = P_NX_SUB;
      4'd2:    cross_op = P_NY_LD;
      4'd3:    cross_op = P_NY_SUB;
      4'd4:    cross_op = P_NZ_LD;
      default: cross_op = P_NZ_SUB;
    endcase
  endfunction

  // Saturating add of a face normal component into a vertex accumulator.
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [NRM_W-1:0] n);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {{(ACC_W + 1 - NRM_W){n[NRM_W-1]}}, n};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage

[rtl/vna_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/vna_sqrt.sv]
// ---------------------------------------------------------------------------
// Integer square root
// Digit-by-digit root of the sum of squares, one result bit per cycle.
// ---------------------------------------------------------------------------
module vna_sqrt
  import vna_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  radicand_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int STEP_W = $clog2(ROOT_W);

  logic              busy_q, busy_d, done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  op_q, op_d, res_q, res_d, one_q, one_d;
  logic [SUM_W-1:0]  trial;

  assign trial = res_q + one_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    op_d   = op_q;
    res_d  = res_q;
    one_d  = one_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      op_d   = radicand_i;
      res_d  = '0;
      one_d  = SUM_W'(1) << (2 * ROOT_W - 2);
    end else if (busy_q) begin
      if (op_q >= trial) begin
        op_d  = op_q - trial;
        res_d = (res_q >> 1) + one_q;
      end else begin
        res_d = res_q >> 1;
      end
      one_d  = one_q >> 2;
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    op_q   <= op_d;
    res_q  <= res_d;
    one_q  <= one_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

[rtl/vna_dp.sv]
// ---------------------------------------------------------------------------
// Vertex normal averager datapath
// Position and accumulator stores, shared multiplier, root and divider steps.
// ---------------------------------------------------------------------------
module vna_dp
  import vna_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [1:0]            in_cmd_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_kind_o,
  output logic                  out_last_o
);

  // Captured input item.
  logic [1:0]       cmd_q;
  logic [IDX_W-1:0] vi_q, ca_q, cb_q, cc_q;
  logic [POS_W-1:0] px_q, py_q, pz_q;
  logic             g_q;
  logic [TOT_W-1:0] tot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      cmd_q <= in_cmd_i;
      vi_q  <= in_data_i[5:0];
      px_q  <= in_data_i[21:6];
      py_q  <= in_data_i[37:22];
      pz_q  <= in_data_i[53:38];
      ca_q  <= in_data_i[59:54];
      cb_q  <= in_data_i[65:60];
      cc_q  <= in_data_i[71:66];
      g_q   <= in_data_i[72];
      tot_q <= in_data_i[79:73];
    end
  end

  logic [TOT_W-1:0] tot_c;
  assign tot_c = (tot_q > TOT_W'(MAX_VERTICES)) ? TOT_W'(MAX_VERTICES) : tot_q;

  logic [IDX_W-1:0] corner;
  always_comb begin
    case (cmd_i.comp)
      2'd0:    corner = ca_q;
      2'd1:    corner = cb_q;
      default: corner = cc_q;
    endcase
  end

  // Position store.
  logic [POS_WORD_W-1:0] pos_rdata;
  logic                  vi_ok;
  assign vi_ok = (TOT_W'(vi_q) < TOT_W'(MAX_VERTICES));

  vna_ram #(.WIDTH(POS_WORD_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.pos_we & vi_ok),
    .waddr_i(vi_q[AW-1:0]),
    .wdata_i({pz_q, py_q, px_q}),
    .re_i   (cmd_i.pos_re),
    .raddr_i(corner[AW-1:0]),
    .rdata_o(pos_rdata)
  );

  logic signed [POS_W-1:0] rx, ry, rz;
  assign rx = pos_rdata[POS_W-1:0];
  assign ry = pos_rdata[2*POS_W-1:POS_W];
  assign rz = pos_rdata[3*POS_W-1:2*POS_W];

  logic signed [POS_W-1:0] pax_q, pay_q, paz_q;
  logic signed [DIF_W-1:0] d1x_q, d1y_q, d1z_q, d2x_q, d2y_q, d2z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_pa) begin
      pax_q <= rx;
      pay_q <= ry;
      paz_q <= rz;
    end
    if (cmd_i.lat_d1) begin
      d1x_q <= DIF_W'(pax_q) - DIF_W'(rx);
      d1y_q <= DIF_W'(pay_q) - DIF_W'(ry);
      d1z_q <= DIF_W'(paz_q) - DIF_W'(rz);
    end
    if (cmd_i.lat_d2) begin
      d2x_q <= DIF_W'(pax_q) - DIF_W'(rx);
      d2y_q <= DIF_W'(pay_q) - DIF_W'(ry);
      d2z_q <= DIF_W'(paz_q) - DIF_W'(rz);
    end
  end

  // Face normal and its component magnitudes.
  logic signed [NRM_W-1:0] nx_q, ny_q, nz_q, nsel;
  logic [NRM_W-1:0]        nmag;
  always_comb begin
    case (cmd_i.comp)
      2'd0:    nsel = nx_q;
      2'd1:    nsel = ny_q;
      default: nsel = nz_q;
    endcase
    nmag = nsel[NRM_W-1] ? NRM_W'(-nsel) : NRM_W'(nsel);
  end

  // Finish path magnitudes, signs and results.
  logic [ACC_W-1:0] fmx_q, fmy_q, fmz_q, fmsel;
  logic             fsx_q, fsy_q, fsz_q, fssel, ftouch_q;
  always_comb begin
    case (cmd_i.comp)
      2'd0:    begin fmsel = fmx_q; fssel = fsx_q; end
      2'd1:    begin fmsel = fmy_q; fssel = fsy_q; end
      default: begin fmsel = fmz_q; fssel = fsz_q; end
    endcase
  end

  // Shared multiplier with its product register.
  logic signed [MUL_W-1:0]  opa, opb;
  logic signed [PROD_W-1:0] prod, p_q;

  function automatic logic signed [MUL_W-1:0] sx(input logic signed [DIF_W-1:0] v);
    sx = {{(MUL_W - DIF_W){v[DIF_W-1]}}, v};
  endfunction

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_YZ:    begin opa = sx(d1y_q); opb = sx(d2z_q); end
      MUL_ZY:    begin opa = sx(d1z_q); opb = sx(d2y_q); end
      MUL_ZX:    begin opa = sx(d1z_q); opb = sx(d2x_q); end
      MUL_XZ:    begin opa = sx(d1x_q); opb = sx(d2z_q); end
      MUL_XY:    begin opa = sx(d1x_q); opb = sx(d2y_q); end
      MUL_YX:    begin opa = sx(d1y_q); opb = sx(d2x_q); end
      MUL_SQ_HH: begin
        opa = MUL_W'(nmag[NRM_W-1:HALF_W]);
        opb = MUL_W'(nmag[NRM_W-1:HALF_W]);
      end
      MUL_SQ_HL: begin
        opa = MUL_W'(nmag[NRM_W-1:HALF_W]);
        opb = MUL_W'(nmag[HALF_W-1:0]);
      end
      MUL_SQ_LL: begin
        opa = MUL_W'(nmag[HALF_W-1:0]);
        opb = MUL_W'(nmag[HALF_W-1:0]);
      end
      MUL_FIN:   begin opa = MUL_W'(fmsel[FM_W-1:0]); opb = MUL_W'(fmsel[FM_W-1:0]); end
      default:   begin opa = '0; opb = '0; end
    endcase
  end

  assign prod = opa * opb;

  logic [SUM_W-1:0] sum_q, addend;
  assign addend = {{(SUM_W - PROD_W + 2){1'b0}}, p_q[PROD_W-3:0]};

  always_ff @(posedge clk_i) begin
    p_q <= prod;
    case (cmd_i.p_op)
      P_NX_LD:  nx_q <= p_q[NRM_W-1:0];
      P_NX_SUB: nx_q <= nx_q - p_q[NRM_W-1:0];
      P_NY_LD:  ny_q <= p_q[NRM_W-1:0];
      P_NY_SUB: ny_q <= ny_q - p_q[NRM_W-1:0];
      P_NZ_LD:  nz_q <= p_q[NRM_W-1:0];
      P_NZ_SUB: nz_q <= nz_q - p_q[NRM_W-1:0];
      P_ADD_HH: sum_q <= sum_q + (addend << (2 * HALF_W));
      P_ADD_HL: sum_q <= sum_q + (addend << (HALF_W + 1));
      P_ADD_LL: sum_q <= sum_q + addend;
      default:  ;
    endcase
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
    end
  end

  // Square root unit and the latched length.
  logic              sqrt_done;
  logic [ROOT_W-1:0] root, len_q;

  vna_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.sqrt_start),
    .radicand_i(sum_q),
    .done_o    (sqrt_done),
    .root_o    (root)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_lat) begin
      len_q <= root;
    end
  end

  // Accumulator store; an entry whose valid bit is clear reads as zero.
  logic [ACC_WORD_W-1:0]   acc_rdata, acc_cur, acc_wdata;
  logic [AW-1:0]           acc_raddr, acc_addr_q;
  logic [MAX_VERTICES-1:0] valid_q;
  logic [CNT_W-1:0]        vc_q;

  assign acc_raddr = cmd_i.acc_vert ? vc_q[AW-1:0] : corner[AW-1:0];
  assign acc_cur   = valid_q[acc_addr_q] ? acc_rdata : '0;

  logic signed [ACC_W-1:0] cax, cay, caz;
  logic [TCNT_W-1:0]       ctc, ntc;
  assign cax = acc_cur[ACC_W-1:0];
  assign cay = acc_cur[2*ACC_W-1:ACC_W];
  assign caz = acc_cur[3*ACC_W-1:2*ACC_W];
  assign ctc = acc_cur[ACC_WORD_W-1:3*ACC_W];
  assign ntc = (ctc == {TCNT_W{1'b1}}) ? ctc : ctc + TCNT_W'(1);
  assign acc_wdata = {ntc, sat_add(caz, nz_q), sat_add(cay, ny_q), sat_add(cax, nx_q)};

  vna_ram #(.WIDTH(ACC_WORD_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.acc_we),
    .waddr_i(acc_addr_q),
    .wdata_i(acc_wdata),
    .re_i   (cmd_i.acc_re),
    .raddr_i(acc_raddr),
    .rdata_o(acc_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_re) begin
      acc_addr_q <= acc_raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.valid_clr) begin
      valid_q <= '0;
    end else if (cmd_i.acc_we) begin
      valid_q[acc_addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vc_clr) begin
      vc_q <= '0;
    end else if (cmd_i.vc_inc) begin
      vc_q <= vc_q + CNT_W'(1);
    end
  end

  // Finish path: magnitudes, normalising shift and per-component division.
  logic [REM_W-1:0]        rem_q, dv_q;
  logic [QN_W-1:0]         dq_q;
  logic signed [OUT_N_W-1:0] qx_q, qy_q, qz_q, qval;

  assign qval = fssel ? -OUT_N_W'(dq_q) : OUT_N_W'(dq_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.f_lat) begin
      fmx_q    <= cax[ACC_W-1] ? ACC_W'(-cax) : ACC_W'(cax);
      fmy_q    <= cay[ACC_W-1] ? ACC_W'(-cay) : ACC_W'(cay);
      fmz_q    <= caz[ACC_W-1] ? ACC_W'(-caz) : ACC_W'(caz);
      fsx_q    <= cax[ACC_W-1];
      fsy_q    <= cay[ACC_W-1];
      fsz_q    <= caz[ACC_W-1];
      ftouch_q <= (ctc != '0);
      qx_q     <= '0;
      qy_q     <= '0;
      qz_q     <= '0;
    end
    if (cmd_i.f_shift) begin
      fmx_q <= fmx_q >> 1;
      fmy_q <= fmy_q >> 1;
      fmz_q <= fmz_q >> 1;
    end
    if (cmd_i.div_init) begin
      rem_q <= (REM_W'(fmsel[FM_W-1:0]) << FRAC_W) + REM_W'(len_q[ROOT_W-1:1]);
      dv_q  <= REM_W'(len_q) << FRAC_W;
      dq_q  <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_q >= dv_q) begin
        rem_q <= rem_q - dv_q;
        dq_q  <= {dq_q[QN_W-2:0], 1'b1};
      end else begin
        dq_q  <= {dq_q[QN_W-2:0], 1'b0};
      end
      dv_q <= dv_q >> 1;
    end
    if (cmd_i.div_store) begin
      case (cmd_i.comp)
        2'd0:    qx_q <= qval;
        2'd1:    qy_q <= qval;
        default: qz_q <= qval;
      endcase
    end
  end

  // Output register.
  logic                 ovalid_q, olast_q, otouch_q;
  kind_e                okind_q;
  logic [ROOT_W-1:0]    opoly_q;
  logic [IDX_W-1:0]     oidx_q;
  logic [OUT_N_W-1:0]   onx_q, ony_q, onz_q;
  logic                 out_free;

  assign out_free = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      okind_q <= cmd_i.out_kind;
      if (cmd_i.out_kind == KIND_TRI) begin
        opoly_q  <= len_q;
        oidx_q   <= '0;
        onx_q    <= '0;
        ony_q    <= '0;
        onz_q    <= '0;
        otouch_q <= 1'b0;
        olast_q  <= 1'b0;
      end else begin
        opoly_q  <= '0;
        oidx_q   <= IDX_W'(vc_q);
        onx_q    <= qx_q;
        ony_q    <= qy_q;
        onz_q    <= qz_q;
        otouch_q <= ftouch_q;
        olast_q  <= (vc_q + CNT_W'(1) == CNT_W'(tot_c));
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_kind_o  = okind_q;
  assign out_last_o  = olast_q;
  assign out_data_o  = {5'b0, otouch_q, onz_q, ony_q, onx_q, oidx_q, opoly_q};

  // Status towards the controller.
  always_comb begin
    stat_o.cmd        = cmd_e'(cmd_q);
    stat_o.cmd_known  = (cmd_q != 2'd3);
    stat_o.tri_ok     = g_q && (TOT_W'(ca_q) < TOT_W'(MAX_VERTICES))
                            && (TOT_W'(cb_q) < TOT_W'(MAX_VERTICES))
                            && (TOT_W'(cc_q) < TOT_W'(MAX_VERTICES));
    stat_o.total_zero = (tot_q == '0);
    stat_o.vc_last    = (vc_q + CNT_W'(1) == CNT_W'(tot_c));
    stat_o.out_free   = out_free;
    stat_o.need_shift = (fmx_q[ACC_W-1:FM_W] != '0) || (fmy_q[ACC_W-1:FM_W] != '0)
                        || (fmz_q[ACC_W-1:FM_W] != '0);
    stat_o.norm_zero  = !ftouch_q || ((fmx_q == '0) && (fmy_q == '0) && (fmz_q == '0));
    stat_o.sqrt_done  = sqrt_done;
  end

endmodule

[rtl/vna_ctrl.sv]
// ---------------------------------------------------------------------------
// Vertex normal averager controller
// Sequences loads, triangle passes and the finish walk over the datapath.
// ---------------------------------------------------------------------------
module vna_ctrl
  import vna_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d, part_q, part_d;
  p_op_e      pop_q, pop_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
      part_q  <= '0;
      pop_q   <= P_NONE;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      part_q  <= part_d;
      pop_q   <= pop_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    comp_d     = comp_q;
    part_d     = part_q;
    pop_d      = P_NONE;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.p_op = pop_q;
    cmd_o.comp = comp_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat_i.cmd)
          CMD_LOAD: begin
            cmd_o.pos_we = stat_i.cmd_known;
            state_d      = ST_IDLE;
          end
          CMD_TRI: begin
            state_d = stat_i.tri_ok ? ST_RD_A : ST_IDLE;
          end
          CMD_FIN: begin
            cmd_o.vc_clr = 1'b1;
            state_d      = stat_i.total_zero ? ST_F_CLR : ST_F_RD;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_RD_A: begin
        cmd_o.pos_re = 1'b1;
        cmd_o.comp   = 2'd0;
        state_d      = ST_RD_B;
      end
      ST_RD_B: begin
        cmd_o.pos_re = 1'b1;
        cmd_o.comp   = 2'd1;
        cmd_o.lat_pa = 1'b1;
        state_d      = ST_RD_C;
      end
      ST_RD_C: begin
        cmd_o.pos_re = 1'b1;
        cmd_o.comp   = 2'd2;
        cmd_o.lat_d1 = 1'b1;
        state_d      = ST_LAT_C;
      end
      ST_LAT_C: begin
        cmd_o.lat_d2  = 1'b1;
        cmd_o.sum_clr = 1'b1;
        cnt_d         = '0;
        state_d       = ST_CROSS;
      end
      ST_CROSS: begin
        cmd_o.mul_sel = cross_mul(cnt_q);
        pop_d         = cross_op(cnt_q);
        cnt_d         = cnt_q + 4'd1;
        if (cnt_q == 4'd5) begin
          comp_d  = '0;
          part_d  = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        case (part_q)
          2'd0:    begin cmd_o.mul_sel = MUL_SQ_HH; pop_d = P_ADD_HH; end
          2'd1:    begin cmd_o.mul_sel = MUL_SQ_HL; pop_d = P_ADD_HL; end
          default: begin cmd_o.mul_sel = MUL_SQ_LL; pop_d = P_ADD_LL; end
        endcase
        part_d = part_q + 2'd1;
        if (part_q == 2'd2) begin
          part_d = '0;
          if (comp_q == 2'd2) begin
            state_d = ST_DRAIN;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end
      end
      ST_DRAIN: state_d = ST_SQRT_GO;
      ST_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (stat_i.sqrt_done) begin
          cmd_o.len_lat = 1'b1;
          comp_d        = '0;
          state_d       = (stat_i.cmd == CMD_FIN) ? ST_F_DIV_INIT : ST_ACC_RD;
        end
      end
      ST_ACC_RD: begin
        cmd_o.acc_re = 1'b1;
        state_d      = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        cmd_o.acc_we = 1'b1;
        if (comp_q == 2'd2) begin
          state_d = ST_EMIT_T;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_ACC_RD;
        end
      end
      ST_EMIT_T: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_TRI;
          state_d        = ST_IDLE;
        end
      end
      ST_F_RD: begin
        cmd_o.acc_re   = 1'b1;
        cmd_o.acc_vert = 1'b1;
        state_d        = ST_F_LAT;
      end
      ST_F_LAT: begin
        cmd_o.f_lat = 1'b1;
        state_d     = ST_F_CHK;
      end
      ST_F_CHK: state_d = stat_i.norm_zero ? ST_F_EMIT : ST_F_SHIFT;
      ST_F_SHIFT: begin
        if (stat_i.need_shift) begin
          cmd_o.f_shift = 1'b1;
        end else begin
          cmd_o.sum_clr = 1'b1;
          comp_d        = '0;
          state_d       = ST_F_SQ;
        end
      end
      ST_F_SQ: begin
        cmd_o.mul_sel = MUL_FIN;
        pop_d         = P_ADD_LL;
        if (comp_q == 2'd2) begin
          state_d = ST_DRAIN;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      ST_F_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = ST_F_DIV_STEP;
      end
      ST_F_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 4'd1;
        if (cnt_q == 4'(QN_W - 1)) begin
          state_d = ST_F_DIV_ST;
        end
      end
      ST_F_DIV_ST: begin
        cmd_o.div_store = 1'b1;
        if (comp_q == 2'd2) begin
          state_d = ST_F_EMIT;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_F_DIV_INIT;
        end
      end
      ST_F_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_VERT;
          cmd_o.vc_inc   = 1'b1;
          state_d        = stat_i.vc_last ? ST_F_CLR : ST_F_RD;
        end
      end
      ST_F_CLR: begin
        cmd_o.valid_clr = 1'b1;
        state_d         = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[rtl/vertex_normal_averager_unit.sv]
// ---------------------------------------------------------------------------
// Vertex normal averager
// Gouraud per-vertex normals from triangle cross products, in fixed point.
// ---------------------------------------------------------------------------
// A load item passes only the idle and decode states; a triangle spends most
// time in the one-bit-per-cycle square root (36 steps) and in the cross product
// and squares sequenced on the single shared multiplier. Finish: an untouched or
// zero vertex is read, latched, checked and emitted; any other adds a normalising
// shift of up to 18 steps, a root and three 15-step divisions.
// One item at a time; results wait in an output register; reset clears valid bits.
module vertex_normal_averager_unit
  import vna_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // vertex_index[5:0], pos_x[21:6], pos_y[37:22], pos_z[53:38], corner_a[59:54],
  // corner_b[65:60], corner_c[71:66], is_gouraud[72], vertex_total[79:73]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // poly_length[35:0], out_index[41:36], normal_x[57:42], normal_y[73:58],
  // normal_z[89:74], touched[90], zero padding above
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // kind[0]
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller only takes an item when it is back in its idle state;
  // the output register lets a finished result wait while the next starts.
  vna_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // The datapath holds both stores, the shared multiplier, the root unit,
  // the divider steps and the output register.
  vna_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (s_axis_tdata),
    .in_cmd_i   (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_kind_o (m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

endmodule

[tb/vertex_normal_averager_unit_chk.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Vertex normal averager checker
// Watches both streams, predicts every result and compares it field by field.
// ---------------------------------------------------------------------------
module vertex_normal_averager_unit_chk
  import vna_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tuser,
  input  logic                  m_axis_tlast,
  output int                    fail_cnt_o,
  output int                    pending_o
);

  typedef struct packed {
    logic        kind;
    logic [35:0] length;
    logic [5:0]  index;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        touched;
    logic        last;
  } normal_res_t;

  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;

  logic signed [15:0] pos_x[MAX_VERTICES];
  logic signed [15:0] pos_y[MAX_VERTICES];
  logic signed [15:0] pos_z[MAX_VERTICES];
  longint             sum_x[MAX_VERTICES];
  longint             sum_y[MAX_VERTICES];
  longint             sum_z[MAX_VERTICES];
  int unsigned        hits[MAX_VERTICES];
  normal_res_t        normals_q[$];
  int                 fails = 0;

  assign pending_o  = normals_q.size();
  assign fail_cnt_o = fails;

  task automatic enqueue_result(normal_res_t r);
    normals_q = {normals_q, r};
  endtask

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [35:0] root72(logic [71:0] s);
    logic [35:0] r;
    logic [35:0] t;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      t = r | (36'd1 << b);
      if (72'(t) * 72'(t) <= s) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] root64(logic [63:0] s);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (64'(t) * 64'(t) <= s) r = t;
    end
    return r;
  endfunction

  function automatic longint clamp_add(longint a, longint n);
    longint s;
    s = a + n;
    if (s > SAT_HI) return SAT_HI;
    if (s < SAT_LO) return SAT_LO;
    return s;
  endfunction

  function automatic logic [15:0] unit_comp(longint c, int sh, logic [63:0] len);
    logic [63:0] q;
    q = ((magnitude(c) >> sh) * 64'd16384 + len / 2) / len;
    if (c < 0) q = -q;
    return q[15:0];
  endfunction

  task automatic add_face(int i, longint nx, longint ny, longint nz);
    sum_x[i] = clamp_add(sum_x[i], nx);
    sum_y[i] = clamp_add(sum_y[i], ny);
    sum_z[i] = clamp_add(sum_z[i], nz);
    if (hits[i] < 65535) hits[i]++;
  endtask

  task automatic predict_face(int a, int b, int c);
    longint      l1x, l1y, l1z, l2x, l2y, l2z, nx, ny, nz;
    logic [63:0] mx, my, mz;
    normal_res_t r;
    l1x = longint'(pos_x[a]) - longint'(pos_x[b]);
    l1y = longint'(pos_y[a]) - longint'(pos_y[b]);
    l1z = longint'(pos_z[a]) - longint'(pos_z[b]);
    l2x = longint'(pos_x[a]) - longint'(pos_x[c]);
    l2y = longint'(pos_y[a]) - longint'(pos_y[c]);
    l2z = longint'(pos_z[a]) - longint'(pos_z[c]);
    nx = l1y * l2z - l1z * l2y;
    ny = l1z * l2x - l1x * l2z;
    nz = l1x * l2y - l1y * l2x;
    mx = magnitude(nx);
    my = magnitude(ny);
    mz = magnitude(nz);
    r = '0;
    r.kind = KIND_TRI;
    r.length = root72(72'(mx) * 72'(mx) + 72'(my) * 72'(my) + 72'(mz) * 72'(mz));
    enqueue_result(r);
    add_face(a, nx, ny, nz);
    add_face(b, nx, ny, nz);
    add_face(c, nx, ny, nz);
  endtask

  task automatic predict_finish(int total);
    logic [63:0] mx, my, mz, m, ax, ay, az, len;
    int          sh;
    normal_res_t r;
    if (total > MAX_VERTICES) total = MAX_VERTICES;
    for (int v = 0; v < total; v++) begin
      r = '0;
      r.kind  = KIND_VERT;
      r.index = 6'(v);
      r.last  = (v + 1 == total);
      if (hits[v] != 0) begin
        r.touched = 1'b1;
        mx = magnitude(sum_x[v]);
        my = magnitude(sum_y[v]);
        mz = magnitude(sum_z[v]);
        m = mx;
        if (my > m) m = my;
        if (mz > m) m = mz;
        if (m != 0) begin
          sh = 0;
          while ((m >> sh) >= (64'd1 << 30)) sh++;
          ax = mx >> sh;
          ay = my >> sh;
          az = mz >> sh;
          len = 64'(root64(ax * ax + ay * ay + az * az));
          r.nx = unit_comp(sum_x[v], sh, len);
          r.ny = unit_comp(sum_y[v], sh, len);
          r.nz = unit_comp(sum_z[v], sh, len);
        end
      end
      enqueue_result(r);
    end
    for (int v = 0; v < MAX_VERTICES; v++) begin
      sum_x[v] = 0;
      sum_y[v] = 0;
      sum_z[v] = 0;
      hits[v]  = 0;
    end
  endtask

  task automatic compare_field(string name, logic [35:0] exp_v, logic [35:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  initial begin
    for (int v = 0; v < MAX_VERTICES; v++) begin
      pos_x[v] = '0;
      pos_y[v] = '0;
      pos_z[v] = '0;
      sum_x[v] = 0;
      sum_y[v] = 0;
      sum_z[v] = 0;
      hits[v]  = 0;
    end
  end

  always @(posedge clk_i) begin
    normal_res_t e;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      case (s_axis_tuser)
        CMD_LOAD: begin
          pos_x[s_axis_tdata[5:0]] = s_axis_tdata[21:6];
          pos_y[s_axis_tdata[5:0]] = s_axis_tdata[37:22];
          pos_z[s_axis_tdata[5:0]] = s_axis_tdata[53:38];
        end
        CMD_TRI: begin
          if (s_axis_tdata[72])
            predict_face(s_axis_tdata[59:54], s_axis_tdata[65:60], s_axis_tdata[71:66]);
        end
        CMD_FIN: predict_finish(s_axis_tdata[79:73]);
        default: ;
      endcase
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (normals_q.size() == 0) begin
        $error("unexpected result: tdata %0h", m_axis_tdata);
        fails++;
      end else begin
        e = normals_q.pop_front();
        compare_field("kind", e.kind, m_axis_tuser);
        compare_field("poly_length", e.length, m_axis_tdata[35:0]);
        compare_field("out_index", e.index, m_axis_tdata[41:36]);
        compare_field("normal_x", e.nx, m_axis_tdata[57:42]);
        compare_field("normal_y", e.ny, m_axis_tdata[73:58]);
        compare_field("normal_z", e.nz, m_axis_tdata[89:74]);
        compare_field("touched", e.touched, m_axis_tdata[90]);
        compare_field("last", e.last, m_axis_tlast);
      end
    end
  end

endmodule

[tb/vertex_normal_averager_unit_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Vertex normal averager testbench
// Drives loads, triangles, spare commands and finish runs with random gaps
// and stalls; the checker predicts every result and counts mismatches.
// ---------------------------------------------------------------------------
module vertex_normal_averager_unit_tb;
  import vna_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = CMD_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  int                    fail_cnt;
  int                    pending;
  logic                  src_gaps = 1'b1;
  logic [63:0]           loaded = '0;
  int                    cycle_cnt = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  vertex_normal_averager_unit i_dut (.*);

  vertex_normal_averager_unit_chk i_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // Offers one item and holds it until accepted; tvalid is only lowered
  // inside a gap, so it is never dropped and raised in the same step.
  task automatic offer(logic [1:0] c, logic [IN_DATA_W-1:0] d);
    while (src_gaps && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic load_vertex(int vi, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    loaded[vi] = 1'b1;
    offer(CMD_LOAD, {26'($urandom), z, y, x, 6'(vi)});
  endtask

  task automatic face(int a, int b, int c, logic g);
    offer(CMD_TRI, {7'($urandom_range(127)), g, 6'(c), 6'(b), 6'(a), 54'({$urandom, $urandom})});
  endtask

  task automatic finish_run(int total);
    offer(CMD_FIN, {7'(total), 73'({$urandom, $urandom, $urandom})});
  endtask

  function automatic int any_loaded();
    int v;
    do v = $urandom_range(63); while (!loaded[v]);
    return v;
  endfunction

  // Receiver: occasional random stalls, one long hold-off to back the block
  // up, and a quiet stretch with no stalls at all.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (cycle_cnt == 6000) begin
        m_axis_tready <= 1'b0;
        for (hold = 0; hold < 3000; hold++) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (cycle_cnt > 15000 && cycle_cnt < 25000) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 6);
      end
    end
  end

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int roll;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: corner positions, degenerate and non-Gouraud faces,
    // the spare command, zero and oversized totals.
    load_vertex(0, 16'h8000, 16'h8000, 16'h8000);
    load_vertex(1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    load_vertex(2, 16'h7FFF, 16'h8000, 16'h0000);
    load_vertex(63, 16'h5555, 16'hAAAA, 16'hFFFF);
    load_vertex(3, 16'h0000, 16'h0000, 16'h0000);
    face(0, 1, 2, 1'b1);
    face(0, 1, 2, 1'b0);
    face(63, 63, 63, 1'b1);
    face(2, 3, 63, 1'b1);
    offer(CMD_SPARE, {$urandom, $urandom, 16'($urandom)});
    finish_run(0);
    face(0, 1, 2, 1'b1);
    finish_run(127);
    face(1, 2, 3, 1'b1);
    face(3, 2, 1, 1'b1);
    finish_run(4);
    finish_run(64);

    // Random part: mostly loads and triangles over loaded slots.
    for (int n = 0; n < 210; n++) begin
      src_gaps = !(n >= 90 && n < 140);
      roll = $urandom_range(99);
      if (roll < 40) begin
        load_vertex($urandom_range(63), 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (roll < 86) begin
        face(any_loaded(), any_loaded(), any_loaded(), $urandom_range(99) < 85);
      end else if (roll < 89) begin
        offer(CMD_SPARE, {$urandom, $urandom, 16'($urandom)});
      end else begin
        roll = $urandom_range(9);
        finish_run(roll < 7 ? $urandom_range(12) : (roll < 9 ? 64 : $urandom_range(127, 65)));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
